// ----- rtl/lru_key_value_cache_defines.svh -----
// ---------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LKVC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lkvc assertion failed");
// Next-cycle implication.
`define LKVC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define LKVC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/lkvc_pkg.sv -----
// ---------------------------------------------------------------------------
// LRU key/value cache package
// Sizes, item types and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 5;
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
        logic               evicted;
    } t_result;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_FILL,
        OP_EVICT
    } t_op;

    typedef struct packed {
        logic load;
        logic match;
        logic apply;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic room;
    } t_status;

endpackage

// ----- rtl/lkvc_ctrl.sv -----
// ---------------------------------------------------------------------------
// LRU cache controller
// Sequences load, match and apply; picks the update operation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lkvc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_strobe,
    input  lkvc_pkg::t_status i_status,
    output lkvc_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    t_state       r_state, n_state;
    logic         r_busy, n_busy;
    logic         r_strobe, n_strobe;
    lkvc_pkg::t_op r_op, n_op;

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        n_op     = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MATCH;
                    n_busy  = 1'b1;
                end
            end
            S_MATCH: begin
                n_state = S_APPLY;
                priority if (i_status.hit) begin
                    n_op = lkvc_pkg::OP_TOUCH;
                end else if (i_status.is_put && i_status.room) begin
                    n_op = lkvc_pkg::OP_FILL;
                end else if (i_status.is_put) begin
                    n_op = lkvc_pkg::OP_EVICT;
                end else begin
                    n_op = lkvc_pkg::OP_NONE;
                end
            end
            S_APPLY: begin
                n_state  = S_IDLE;
                n_busy   = 1'b0;
                n_strobe = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_op     <= lkvc_pkg::OP_NONE;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_op     <= n_op;
        end
    end

    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_start;
        o_cmd.match = (r_state == S_MATCH);
        o_cmd.apply = (r_state == S_APPLY);
        o_cmd.op    = r_op;
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

// ----- rtl/lkvc_datapath.sv -----
// ---------------------------------------------------------------------------
// LRU cache datapath
// Entry storage, parallel key/rank match and recency update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lkvc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkvc_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]    i_cfg_data,
    input  lkvc_pkg::t_cmd                i_cmd,
    output lkvc_pkg::t_status             o_status,
    output lkvc_pkg::t_result             o_result
);

    localparam int N  = lkvc_pkg::CAPACITY;
    localparam int IW = lkvc_pkg::IDX_W;
    localparam int CW = lkvc_pkg::CNT_W;
    localparam int MW = lkvc_pkg::CMP_W;

    logic signed [31:0]          r_keys [N];
    logic signed [31:0]          r_vals [N];
    logic [N-1:0]                r_valid;
    logic [IW-1:0]               r_rank [N];
    logic [CW-1:0]               r_occ;
    logic [lkvc_pkg::CFG_W-1:0]  r_cap;
    lkvc_pkg::t_item             r_item;
    logic [IW-1:0]               r_tgt;
    lkvc_pkg::t_result           r_result;

    logic [N-1:0]  hit_vec, lru_vec;
    logic [IW-1:0] hit_idx, lru_idx, free_idx, tgt;
    logic [IW-1:0] occ_m1;
    logic [MW-1:0] cap_x, eff_cap;
    logic          room;

    // Parallel match over all entries; lowest index wins.
    always_comb begin
        occ_m1   = IW'(r_occ - 1'b1);
        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < N; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == r_item.key);
            lru_vec[i] = r_valid[i] && (r_rank[i] == occ_m1);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_idx = IW'(i);
            if (lru_vec[i]) lru_idx = IW'(i);
            if (!r_valid[i]) free_idx = IW'(i);
        end
    end

    // A capacity of zero behaves as one, anything above the size as the size.
    always_comb begin
        cap_x = MW'(r_cap);
        if (cap_x == '0) begin
            eff_cap = MW'(1);
        end else if (cap_x > MW'(N)) begin
            eff_cap = MW'(N);
        end else begin
            eff_cap = cap_x;
        end
        room = MW'(r_occ) < eff_cap;
    end

    always_comb begin
        if (|hit_vec) begin
            tgt = hit_idx;
        end else if (room) begin
            tgt = free_idx;
        end else begin
            tgt = lru_idx;
        end
    end

    assign o_status.is_put = r_item.command;
    assign o_status.hit    = |hit_vec;
    assign o_status.room   = room;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= lkvc_pkg::CFG_RESET;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.apply && (i_cmd.op != lkvc_pkg::OP_NONE)) begin
                for (int i = 0; i < N; i++) begin
                    if (r_valid[i] && (IW'(i) != r_tgt) &&
                        ((i_cmd.op != lkvc_pkg::OP_TOUCH) || (r_rank[i] < r_rank[r_tgt]))) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rank[r_tgt] <= '0;
                if (i_cmd.op == lkvc_pkg::OP_FILL) begin
                    r_valid[r_tgt] <= 1'b1;
                    r_occ          <= r_occ + 1'b1;
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.match) begin
            r_tgt <= tgt;
        end
        if (i_cmd.apply) begin
            r_result.found      <= (i_cmd.op == lkvc_pkg::OP_TOUCH);
            r_result.evicted    <= (i_cmd.op == lkvc_pkg::OP_EVICT);
            r_result.read_value <= ((i_cmd.op == lkvc_pkg::OP_TOUCH) && !r_item.command)
                                   ? r_vals[r_tgt] : 32'sd0;
            if (i_cmd.op == lkvc_pkg::OP_FILL || i_cmd.op == lkvc_pkg::OP_EVICT) begin
                r_keys[r_tgt] <= r_item.key;
            end
            if (r_item.command && (i_cmd.op != lkvc_pkg::OP_NONE)) begin
                r_vals[r_tgt] <= r_item.value;
            end
        end
    end

    assign o_result = r_result;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// ---------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter on i_item when start is high and busy is low. command 0 is a
//   get, 1 a put. Each item gives exactly one result on o_result, marked by
//   o_valid for a single cycle; the receiver cannot hold it off.
//   Sequence: an accepted item passes through key match and then state update,
//   after which the result strobe is registered. busy is high through match
//   and update, so no new item is taken while one is in flight; a new item
//   may be started in the cycle its predecessor's result is shown. The
//   controller's three-step sequence (accept, match, update) sets this order:
//   the parallel key and rank compare in match, the entry and rank writes in update.
//   Capacity in use is written on the i_cfg_* channel (valid/ready), taken
//   only while no item is in flight or being started; 0 acts as 1, above the
//   size as the size.
//   Reset (synchronous, active low) empties the cache, clears all ranks and
//   sets the capacity to the full size; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lkvc_pkg::t_item             i_item,
    output logic                        o_valid,
    output lkvc_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0]  i_cfg_data
);

    lkvc_pkg::t_cmd    cmd;
    lkvc_pkg::t_status status;
    logic              cfg_we;

    // Capacity changes only between items; a starting item takes precedence.
    assign o_cfg_ready = !busy && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    lkvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_valid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lkvc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (o_result)
    );

    // An accepted item keeps the block busy while it is in flight.
    `LKVC_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // The result strobe only comes once the block has released busy.
    `LKVC_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy)
    // One strobe per item: strobes never come back to back.
    `LKVC_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // A replacement only happens on a miss.
    `LKVC_ASSERT_IMP(a_evict_miss, i_clk, i_rst_n, o_valid && o_result.evicted, !o_result.found)

endmodule

// ----- tb/sv/tb_lru_key_value_cache.sv -----
// ---------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and put items through the command port, mirrors the cache
// contents and recency order in a tracker class, and checks every result
// strobe against the tracked state. Capacity is rewritten between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam logic CMD_GET = 1'b0;
localparam logic CMD_PUT = 1'b1;

// Mirror of the cache: keys, values, presence and recency age per entry.
class lru_tracker;
    logic [31:0]                  keys [lkvc_pkg::CAPACITY];
    logic [31:0]                  vals [lkvc_pkg::CAPACITY];
    bit                           live [lkvc_pkg::CAPACITY];
    int unsigned                  age  [lkvc_pkg::CAPACITY];
    int unsigned                  occ;
    logic [lkvc_pkg::CFG_W-1:0]   cap_reg;
    lkvc_pkg::t_result            due_q [$];
    int                           mismatches;
    int                           hits;
    int                           evictions;
    int                           items;

    function new();
        for (int i = 0; i < lkvc_pkg::CAPACITY; i++) begin
            keys[i] = '0;
            vals[i] = '0;
            live[i] = 1'b0;
            age[i]  = 0;
        end
        occ        = 0;
        cap_reg    = lkvc_pkg::CFG_RESET;
        mismatches = 0;
        hits       = 0;
        evictions  = 0;
        items      = 0;
    endfunction

    function void set_capacity(logic [lkvc_pkg::CFG_W-1:0] v);
        cap_reg = v;
    endfunction

    // 0 behaves as 1, anything above the size as the size
    function int unsigned room_limit();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > lkvc_pkg::CAPACITY)
            return lkvc_pkg::CAPACITY;
        return cap_reg;
    endfunction

    // entry e becomes most recent; younger entries age by one
    function void promote(int e);
        for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
            if (live[i] && i != e && age[i] < age[e])
                age[i]++;
        age[e] = 0;
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    function void note_request(lkvc_pkg::t_item it);
        lkvc_pkg::t_result r;
        int                hit_at;
        int                slot;
        int                victim;
        int unsigned       oldest;
        r      = '0;
        hit_at = -1;
        slot   = -1;
        victim = -1;
        oldest = 0;
        items++;
        for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
            if (hit_at < 0 && live[i] && keys[i] == it.key)
                hit_at = i;
        if (hit_at >= 0) begin
            r.found = 1'b1;
            hits++;
            if (it.command == CMD_PUT)
                vals[hit_at] = it.value;
            else
                r.read_value = vals[hit_at];
            promote(hit_at);
        end else if (it.command == CMD_PUT) begin
            if (occ < room_limit()) begin
                for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
                    if (slot < 0 && !live[i])
                        slot = i;
                if (slot >= 0) begin
                    for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
                        if (live[i])
                            age[i]++;
                    live[slot] = 1'b1;
                    keys[slot] = it.key;
                    vals[slot] = it.value;
                    age[slot]  = 0;
                    occ++;
                end
            end else begin
                for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
                    if (live[i] && (victim < 0 || age[i] > oldest)) begin
                        victim = i;
                        oldest = age[i];
                    end
                if (victim >= 0) begin
                    keys[victim] = it.key;
                    vals[victim] = it.value;
                    promote(victim);
                    r.evicted = 1'b1;
                    evictions++;
                end
            end
        end
        due_q.push_back(r);
    endfunction

    function void report(string what, lkvc_pkg::t_result want, lkvc_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): want found=%0d rd=%08h ev=%0d, got found=%0d rd=%08h ev=%0d",
                     what, want.found, want.read_value, want.evicted,
                     got.found, got.read_value, got.evicted);
    endfunction

    function void check_response(lkvc_pkg::t_result got);
        lkvc_pkg::t_result want;
        if (due_q.size() == 0) begin
            report("no item outstanding", '0, got);
        end else begin
            want = due_q.pop_front();
            if (got.found !== want.found)
                report("found", want, got);
            else if (got.read_value !== want.read_value)
                report("read_value", want, got);
            else if (got.evicted !== want.evicted)
                report("evicted", want, got);
        end
    endfunction
endclass

module tb_lru_key_value_cache;

    localparam int RUN_LIMIT = 300000;
    localparam int SEGMENTS  = 19;
    localparam int SEG_ITEMS = 50;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    lkvc_pkg::t_item            i_item;
    logic                       o_valid;
    lkvc_pkg::t_result          o_result;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [lkvc_pkg::CFG_W-1:0] i_cfg_data;

    lru_tracker  tracker;
    int unsigned cycle_count = 0;
    int          cfg_writes  = 0;
    logic [31:0] key_pool [$];

    lru_key_value_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Results cannot be held off: each strobe is checked at the edge ending it.
    // Outputs are read before the edge's updates land, so no ordering race.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            tracker.check_response(o_result);
    end

    // Watchdog: a hung handshake or lost result ends the run here
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("[lru_key_value_cache] ERROR");
        $finish;
    end

    function automatic lkvc_pkg::t_item mk_item(logic cmd, logic [31:0] k, logic [31:0] v);
        lkvc_pkg::t_item it;
        it.command = cmd;
        it.key     = k;
        it.value   = v;
        return it;
    endfunction

    // Hold the item on the port until an edge sees start high with busy low.
    task automatic send_item(lkvc_pkg::t_item it);
        start  <= 1'b1;
        i_item <= it;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        tracker.note_request(it);
    endtask

    // Send one item, then maybe leave start low for a random gap.
    // The gap lengths vary so that restarts land on every step of the item sequence.
    task automatic issue(lkvc_pkg::t_item it, int idle_pct);
        int gap;
        send_item(it);
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender stops until every outstanding result has been seen
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    // Capacity changes only once the cache is idle
    task automatic write_capacity(logic [lkvc_pkg::CFG_W-1:0] v);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        tracker.set_capacity(v);
        cfg_writes++;
    endtask

    // Key pool of one key up to six more than the capacity, so that hits,
    // fills and replacements all occur. Extremes go in now and then.
    task automatic build_pool(int n);
        key_pool.delete();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       key_pool.push_back(32'h8000_0000);
                1:       key_pool.push_back(32'h7FFF_FFFF);
                2:       key_pool.push_back(32'hFFFF_FFFF);
                3:       key_pool.push_back(32'h0000_0000);
                default: key_pool.push_back($urandom);
            endcase
        end
    endtask

    function automatic lkvc_pkg::t_item random_item();
        logic        cmd;
        logic [31:0] k;
        logic [31:0] v;
        cmd = ($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET;
        // an odd fresh key makes a miss likely
        k   = ($urandom_range(0, 15) == 0) ? $urandom
                                           : key_pool[$urandom_range(0, key_pool.size() - 1)];
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            default: v = $urandom;
        endcase
        return mk_item(cmd, k, v);
    endfunction

    initial begin
        int idle_pct;
        int lim;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty cache, extreme keys and values, update, ignored value
        issue(mk_item(CMD_GET, 32'h0000_0000, 32'h0000_0000), 0);   // miss on empty
        issue(mk_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF), 0);
        issue(mk_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000), 0);
        issue(mk_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000), 0);
        issue(mk_item(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
        issue(mk_item(CMD_GET, 32'h8000_0000, 32'h0000_0000), 0);   // hit
        issue(mk_item(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 0);   // value ignored
        issue(mk_item(CMD_PUT, 32'h0000_0000, 32'h1234_5678), 0);   // update in place
        issue(mk_item(CMD_GET, 32'h0000_0000, 32'hA5A5_A5A5), 0);
        issue(mk_item(CMD_GET, 32'h0000_3039, 32'h0000_0000), 0);   // miss, state kept

        // Zero capacity acts as one; four entries already held, none dropped
        write_capacity(5'd0);
        issue(mk_item(CMD_PUT, 32'h0000_0001, 32'h0000_0011), 0);   // replaces oldest
        issue(mk_item(CMD_PUT, 32'h0000_0002, 32'h0000_0022), 0);
        issue(mk_item(CMD_GET, 32'h8000_0000, 32'h0000_0000), 0);   // was oldest: gone
        issue(mk_item(CMD_GET, 32'h0000_0002, 32'h0000_0000), 0);

        // Above the size acts as the size: fills resume
        write_capacity(5'd31);
        issue(mk_item(CMD_PUT, 32'h0000_0003, 32'h0000_0033), 0);
        issue(mk_item(CMD_PUT, 32'h0000_0004, 32'h0000_0044), 0);
        issue(mk_item(CMD_GET, 32'h0000_0001, 32'h0000_0000), 0);

        write_capacity(5'd1);
        issue(mk_item(CMD_PUT, 32'h0000_0005, 32'h0000_0055), 0);
        issue(mk_item(CMD_GET, 32'h0000_0005, 32'h0000_0000), 0);

        // Random segments: sender idles 38 %, then 82 %, then never.
        // Capacity changes per segment, extremes first.
        for (int s = 0; s < SEGMENTS; s++) begin
            idle_pct = (s < 6) ? 38 : (s < 12) ? 82 : 0;
            case (s)
                0:       write_capacity(5'd16);
                1:       write_capacity(5'd1);
                2:       write_capacity(5'd0);
                3:       write_capacity(5'd31);
                4:       write_capacity(5'd17);
                default: write_capacity(lkvc_pkg::CFG_W'($urandom_range(0, 31)));
            endcase
            lim = tracker.room_limit();
            build_pool($urandom_range(1, lim + 6));
            for (int n = 0; n < SEG_ITEMS; n++) begin
                issue(random_item(), idle_pct);
                if (s == 7 && n == SEG_ITEMS / 2)
                    drain();
            end
        end

        drain();
        repeat (6) @(posedge i_clk);

        $display("run covered %0d items: %0d hits, %0d replacements, %0d capacity writes",
                 tracker.items, tracker.hits, tracker.evictions, cfg_writes);
        if (tracker.pending() != 0)
            $display("%0d results never arrived", tracker.pending());
        if (tracker.mismatches > 10)
            $display("%0d mismatches in total", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[lru_key_value_cache] OK");
        else
            $display("[lru_key_value_cache] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache.sv
tb/sv/tb_lru_key_value_cache.sv
